FILE: hw/rtl/rms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg
// shared types and constants of the rms level meter
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int MaxChannels = 8;
  localparam int MaxFrames   = 65536;
  localparam int ChW         = 3;
  localparam int SumW        = 47;
  localparam int FrameW      = 17;
  localparam int QW          = 63;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [17:0] DbPerLog2 = 18'd197283;

  localparam logic [2:0] RegChannelCount = 3'd0;
  localparam logic [2:0] RegFloorDb      = 3'd1;

  typedef struct packed {
    logic acc;
    logic start;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic busy;
  } sts_t;

endpackage

FILE: hw/rtl/rms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_in_if / rms_out_if
// valid/ready channels of the level meter
// ----------------------------------------------------------------------------
interface rms_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample;
  logic last_frame;
  modport source (output valid, sample, last_frame, input ready);
  modport sink (input valid, sample, last_frame, output ready);
endinterface

interface rms_out_if;
  logic valid;
  logic ready;
  logic [2:0] channel;
  logic [6:0] level_percent;
  logic last;
  modport source (output valid, channel, level_percent, last, input ready);
  modport sink (input valid, channel, level_percent, last, output ready);
endinterface

FILE: hw/rtl/rms_level_meter_db_percent_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_level_meter_db_percent_unit
// rms level meter giving per channel levels in percent of a dB range
// ----------------------------------------------------------------------------
// in: one interleaved signed sample per transaction, last_frame marks the
//   packet's final frame. a sample is taken whenever valid is high while accumulating.
// out: after the final frame, one transaction per channel in channel order,
//   last set on the highest channel. the controller's start state after the
//   final sample starts the level unit. a silent channel skips the divide and
//   log2; any other runs a 63-step restoring divide, a normalize search of up to 63
//   steps, ten squaring steps of the log2 and a subtract divide of up to 102 steps.
// in.ready stays low from the final sample until the last level has been
//   taken; a stall on out holds the current level and the whole unit.
// apb: register 0 channel_count at 0x0, register 1 floor_db at 0x4,
//   write only while idle, pready is always high.
// reset: synchronous, sums and frame count cleared, channel_count 1,
//   floor_db 48.
// ----------------------------------------------------------------------------
module rms_level_meter_db_percent_unit (
  input  logic        clk,
  input  logic        rst,
  rms_in_if.sink      in_ch,
  rms_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rms_pkg::cmd_t cmd;
  rms_pkg::sts_t sts;
  logic [3:0] channel_count;
  logic [6:0] floor_db;
  logic [rms_pkg::FrameW-1:0] frames_snap;
  logic [rms_pkg::ChW-1:0] rd_ch;
  logic [rms_pkg::SumW-1:0] rd_sum;
  logic lvl_busy;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 4'd1;
      floor_db <= 7'd48;
    end else if (psel && penable && pwrite) begin
      if (paddr == {rms_pkg::RegChannelCount[0], 2'b00}) channel_count <= pwdata[3:0];
      else if (paddr == {rms_pkg::RegFloorDb[0], 2'b00}) floor_db <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == {rms_pkg::RegChannelCount[0], 2'b00}) prdata = 32'(channel_count);
    else if (paddr == {rms_pkg::RegFloorDb[0], 2'b00}) prdata = 32'(floor_db);
  end

  rms_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_last_frame(in_ch.last_frame),
    .sts, .cmd
  );

  rms_dp u_dp (
    .clk, .rst, .cmd, .sample(in_ch.sample), .channel_count,
    .sts, .frames_snap, .rd_ch, .rd_sum, .lvl_busy
  );

  rms_level u_level (
    .clk, .rst, .start(cmd.start), .nch(channel_count), .floor_db,
    .frames(frames_snap), .rd_ch, .rd_sum, .busy(lvl_busy), .o(out_ch)
  );

endmodule

FILE: hw/rtl/rms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_ctrl
// controller: accumulate, then hand packets to the level unit
// ----------------------------------------------------------------------------
module rms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_last_frame,
  input  rms_pkg::sts_t     sts,
  output rms_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_ACC  = 3'b001,
    ST_START = 3'b010,
    ST_BUSY = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == ST_ACC);
  assign cmd.acc   = (state == ST_ACC) && in_valid;
  assign cmd.start = (state == ST_START);
  assign cmd.clear = (state == ST_START);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC: begin
        if (in_valid && sts.frame_done && in_last_frame) state_next = ST_START;
      end
      ST_START: state_next = ST_BUSY;
      ST_BUSY: begin
        if (!sts.busy) state_next = ST_ACC;
      end
      default: state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_ACC;
    else state <= state_next;
  end

endmodule

FILE: hw/rtl/rms_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_level
// per channel: divide, log2, dB scale, percent map; one result at a time
// ----------------------------------------------------------------------------
module rms_level (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [3:0]                  nch,
  input  logic [6:0]                  floor_db,
  input  logic [rms_pkg::FrameW-1:0]  frames,
  output logic [rms_pkg::ChW-1:0]     rd_ch,
  input  logic [rms_pkg::SumW-1:0]    rd_sum,
  output logic                        busy,
  rms_out_if.source                   o
);

  typedef enum logic [8:0] {
    L_IDLE = 9'b000000001,
    L_LOAD = 9'b000000010,
    L_DIV  = 9'b000000100,
    L_NORM = 9'b000001000,
    L_SQ   = 9'b000010000,
    L_MUL  = 9'b000100000,
    L_PCT  = 9'b001000000,
    L_DIVP = 9'b010000000,
    L_OUT  = 9'b100000000
  } lstate_t;

  lstate_t state;
  logic [rms_pkg::ChW-1:0] ch;
  logic [3:0] n;
  logic [6:0] fl;
  logic [16:0] fr;
  logic [rms_pkg::QW-1:0] q;
  logic [rms_pkg::FrameW:0] rem;
  logic [5:0] cnt;
  logic [5:0] e;
  logic [30:0] m;
  logic [9:0] frac;
  logic lneg;
  logic [34:0] prod;
  logic signed [24:0] num;
  logic [15:0] den;
  logic [8:0] quo;
  logic [25:0] prem;
  logic [62:0] sq;
  logic [rms_pkg::FrameW:0] rem_sh;
  logic [rms_pkg::QW-1:0] dvd;
  logic signed [16:0] l;
  logic [34:0] mag;
  logic signed [16:0] db;
  logic [25:0] prem_sh;

  assign rd_ch = ch;
  assign busy = (state != L_IDLE);
  assign sq = 63'(m) * 63'(m);
  assign rem_sh = {rem[rms_pkg::FrameW-1:0], dvd[rms_pkg::QW-1]};
  assign l = 17'(e) * 17'sd1024 + 17'(frac) - 17'sd47104;
  assign mag = (prod + 35'd131072) >> 18;
  assign db = (mag > 35'd32768) ? (lneg ? -17'sd32768 : 17'sd32767)
            : (lneg ? -17'(mag) : 17'(mag));
  assign prem_sh = {prem[24:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      o.valid <= 1'b0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            ch <= '0;
            n <= (nch == 4'd0) ? 4'd1 : (nch > 4'd8 ? 4'd8 : nch);
            fl <= (floor_db == 7'd0) ? 7'd1 : floor_db;
            state <= L_LOAD;
          end
        end
        L_LOAD: begin
          fr <= 17'(frames);
          dvd <= {rd_sum, 16'd0};
          rem <= '0;
          q <= '0;
          cnt <= 6'd0;
          state <= (rd_sum == '0) ? L_PCT : L_DIV;
          num <= '0;
        end
        L_DIV: begin
          dvd <= dvd << 1;
          if (rem_sh >= {1'b0, fr}) begin
            rem <= rem_sh - {1'b0, fr};
            q <= {q[rms_pkg::QW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q <= {q[rms_pkg::QW-2:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd62) begin
            state <= L_NORM;
            e <= 6'd62;
          end
        end
        L_NORM: begin
          if (q == '0) begin
            num <= '0;
            state <= L_PCT;
          end else if (q[rms_pkg::QW-1 -: 1] == 1'b0 && e != 6'd0) begin
            q <= q << 1;
            e <= e - 6'd1;
          end else begin
            m <= q[62:32];
            frac <= '0;
            cnt <= 6'd0;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          frac <= {frac[8:0], sq[61]};
          m <= sq[61] ? sq[61:31] : sq[60:30];
          cnt <= cnt + 6'd1;
          if (cnt == 6'd9) state <= L_MUL;
        end
        L_MUL: begin
          lneg <= l < 0;
          prod <= 35'(((l < 0) ? 17'(-l) : 17'(l))) * 35'(rms_pkg::DbPerLog2);
          state <= L_PCT;
          cnt <= 6'd0;
        end
        L_PCT: begin
          if (cnt == 6'd0) begin
            den <= {1'b0, fl, 8'd0};
            num <= (q == '0) ? 25'sd0
                 : 25'sd100 * (25'(db) + 25'sd256 * $signed({18'd0, fl}));
          end
          cnt <= 6'd1;
          if (cnt == 6'd1) begin
            if (num <= 0) begin
              quo <= '0;
              state <= L_OUT;
              o.valid <= 1'b1;
            end else begin
              prem <= 26'(2 * num + $signed({10'd0, den}));
              quo <= '0;
              cnt <= 6'd0;
              state <= L_DIVP;
            end
          end
        end
        L_DIVP: begin
          if (prem >= {9'd0, den, 1'b0}) begin
            prem <= prem - {9'd0, den, 1'b0};
            quo <= quo + 9'd1;
          end else begin
            state <= L_OUT;
            o.valid <= 1'b1;
          end
          if (quo >= 9'd101) begin
            state <= L_OUT;
            o.valid <= 1'b1;
          end
        end
        L_OUT: begin
          if (o.ready) begin
            o.valid <= 1'b0;
            if (4'(ch) + 4'd1 == n) state <= L_IDLE;
            else begin
              ch <= ch + 3'd1;
              state <= L_LOAD;
            end
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign o.channel = ch;
  assign o.level_percent = (quo > 9'd100) ? 7'd100 : 7'(quo);
  assign o.last = (4'(ch) + 4'd1 == n);

endmodule

FILE: hw/rtl/rms_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_dp
// datapath: square sums, frame count, snapshot for the level unit
// ----------------------------------------------------------------------------
module rms_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  rms_pkg::cmd_t               cmd,
  input  logic signed [15:0]          sample,
  input  logic [3:0]                  channel_count,
  output rms_pkg::sts_t               sts,
  output logic [rms_pkg::FrameW-1:0]  frames_snap,
  input  logic [rms_pkg::ChW-1:0]     rd_ch,
  output logic [rms_pkg::SumW-1:0]    rd_sum,
  input  logic                        lvl_busy
);

  logic [rms_pkg::SumW-1:0] sums [rms_pkg::MaxChannels];
  logic [rms_pkg::SumW-1:0] snap [rms_pkg::MaxChannels];
  logic [rms_pkg::ChW-1:0] pos;
  logic [rms_pkg::FrameW-1:0] frames;
  logic [31:0] sq;
  logic [rms_pkg::SumW:0] add;
  logic [3:0] n;

  assign n = (channel_count == 4'd0) ? 4'd1 : (channel_count > 4'd8 ? 4'd8 : channel_count);
  assign sq = 32'($signed(sample) * $signed(sample));
  assign add = {1'b0, sums[pos]} + 48'(sq);
  assign sts.frame_done = (4'(pos) + 4'd1 >= n);
  assign sts.busy = lvl_busy;
  assign rd_sum = snap[rd_ch];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      frames <= '0;
      for (int i = 0; i < rms_pkg::MaxChannels; i++) sums[i] <= '0;
    end else if (cmd.clear) begin
      for (int i = 0; i < rms_pkg::MaxChannels; i++) sums[i] <= '0;
      frames <= '0;
    end else if (cmd.acc) begin
      sums[pos] <= add[rms_pkg::SumW] ? rms_pkg::SumMax : add[rms_pkg::SumW-1:0];
      if (sts.frame_done) begin
        pos <= '0;
        if (frames < rms_pkg::FrameW'(rms_pkg::MaxFrames))
          frames <= frames + rms_pkg::FrameW'(1);
      end else pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < rms_pkg::MaxChannels; i++) snap[i] <= sums[i];
      frames_snap <= frames;
    end
  end

endmodule
